@@ rtl/aim_angle_from_offset_core_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the aim angle core.
// Each macro builds one labelled concurrent assertion on the rising clock,
// switched off while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef AIM_ANGLE_FROM_OFFSET_CORE_MACROS_SVH
`define AIM_ANGLE_FROM_OFFSET_CORE_MACROS_SVH

// Same-cycle implication.
`define AAFO_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AAFO_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/aafo_pkg.sv @@
// ---------------------------------------------------------------------------
// aafo_pkg
// Shared constants, types and tables for the aim angle core.
// ---------------------------------------------------------------------------
`default_nettype none

package aafo_pkg;

    // Defaults for the top-level parameters.
    localparam int COORD_WIDTH_DEF     = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 12;
    localparam int CORDIC_STAGES_DEF   = 14;

    // Fixed field widths.
    localparam int RADIUS_W = 15;
    localparam int ANGLE_W  = 16;

    // Angle accumulator is Q30; the CORDIC normalises the larger input to bit 40.
    localparam int ACC_FRAC    = 30;
    localparam int NORM_MSB    = 40;
    localparam int CORDIC_IN_W = 34;
    localparam int XY_W        = 45;
    localparam int Z_W         = 33;
    localparam int ANG_W       = 35;
    localparam int TABLE_LEN   = 24;

    // Sqrt radicand: even left shift of at most 32, aiming at top bit 61 or 62.
    localparam int SQRT_RAD_W   = 64;
    localparam int SQRT_TOP_BIT = 61;
    localparam int SQRT_MAX_K   = 32;
    localparam int YK_W         = RADIUS_W + SQRT_MAX_K / 2;

    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;

    // atan(2^-i) in Q30, truncated.
    localparam logic [30:0] ATAN_TABLE [TABLE_LEN] = '{
        31'h3243F6A8, 31'h1DAC6705, 31'h0FADBAFC, 31'h07F56EA6, 31'h03FEAB76,
        31'h01FFD55B, 31'h00FFFAAA, 31'h007FFF55, 31'h003FFFEA, 31'h001FFFFD,
        31'h000FFFFF, 31'h0007FFFF, 31'h0003FFFF, 31'h0001FFFF, 31'h0000FFFF,
        31'h00007FFF, 31'h00003FFF, 31'h00001FFF, 31'h00000FFF, 31'h000007FF,
        31'h000003FF, 31'h000001FF, 31'h000000FF, 31'h0000007F
    };

    // Classification of one direction, carried alongside the arithmetic.
    typedef struct packed {
        logic dx_zero;
        logic dx_neg;
        logic dy_pos;
        logic mirror;
    } aafo_cls_t;

    // Index of the highest set bit; zero for a zero word.
    function automatic logic [6:0] msb_index(input logic [63:0] v);
        logic [6:0] idx;
        idx = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                idx = 7'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
        return $signed({2'b00, ATAN_TABLE[idx]});
    endfunction

endpackage

`default_nettype wire

@@ rtl/aafo_queue.sv @@
// ---------------------------------------------------------------------------
// aafo_queue
// Short first-in first-out queue between the classifier and the arithmetic.
// ---------------------------------------------------------------------------
`default_nettype none
`include "aim_angle_from_offset_core_macros.svh"

module aafo_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = aafo_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output logic [DATA_W-1:0] pop_data
);
    import aafo_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `AAFO_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count beyond depth")
    `AAFO_ASSERT_IMP(a_pop_nonempty, clk, rst_n, pop, count_reg != '0, "queue popped while empty")
    `AAFO_ASSERT_NXT(a_push_visible, clk, rst_n, push, count_reg != '0, "pushed entry not held")

endmodule

`default_nettype wire

@@ rtl/aafo_front.sv @@
// ---------------------------------------------------------------------------
// aafo_front
// Accepts directions, takes magnitudes and classifies the quadrant, then
// queues the result for the arithmetic pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

module aafo_front #(
    parameter int COORD_WIDTH = aafo_pkg::COORD_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [COORD_WIDTH-1:0]       dir_x,
    input  logic signed [COORD_WIDTH-1:0]       dir_y,
    input  logic [aafo_pkg::RADIUS_W-1:0]       aim_radius,
    input  logic                                mirror,
    input  logic                                pop,
    output logic                                out_valid,
    output logic [COORD_WIDTH-1:0]              out_ux,
    output logic [COORD_WIDTH-1:0]              out_uy,
    output logic signed [COORD_WIDTH:0]         out_cy,
    output logic [aafo_pkg::RADIUS_W-1:0]       out_radius,
    output aafo_pkg::aafo_cls_t                 out_cls
);
    import aafo_pkg::*;

    localparam int CLS_W  = $bits(aafo_cls_t);
    localparam int DATA_W = 3 * COORD_WIDTH + 1 + RADIUS_W + CLS_W;

    logic [COORD_WIDTH-1:0]      ux, uy;
    logic signed [COORD_WIDTH:0] cy, dy_ext;
    aafo_cls_t                   cls;
    logic                        full;
    logic [DATA_W-1:0]           wr_data, rd_data;

    always_comb
    begin
        ux = dir_x[COORD_WIDTH-1] ? (~dir_x + 1'b1) : dir_x;
        uy = dir_y[COORD_WIDTH-1] ? (~dir_y + 1'b1) : dir_y;
        cls.dx_zero = (dir_x == '0);
        cls.dx_neg  = dir_x[COORD_WIDTH-1];
        cls.dy_pos  = !dir_y[COORD_WIDTH-1] && (dir_y != '0);
        cls.mirror  = mirror;
        // Vectoring y input: -dy for a rightward direction, dy otherwise.
        dy_ext = (COORD_WIDTH + 1)'(dir_y);
        cy = (!cls.dx_neg && !cls.dx_zero) ? -dy_ext : dy_ext;
    end

    assign wr_data  = {cls, aim_radius, cy, uy, ux};
    assign in_ready = !full;

    aafo_queue #(
        .DATA_W (DATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !full),
        .push_data (wr_data),
        .full      (full),
        .pop       (pop),
        .not_empty (out_valid),
        .pop_data  (rd_data)
    );

    assign out_ux     = rd_data[COORD_WIDTH-1:0];
    assign out_uy     = rd_data[2*COORD_WIDTH-1:COORD_WIDTH];
    assign out_cy     = $signed(rd_data[3*COORD_WIDTH:2*COORD_WIDTH]);
    assign out_radius = rd_data[3*COORD_WIDTH+RADIUS_W:3*COORD_WIDTH+1];
    assign out_cls    = aafo_cls_t'(rd_data[DATA_W-1:DATA_W-CLS_W]);

endmodule

`default_nettype wire

@@ rtl/aafo_sqrt.sv @@
// ---------------------------------------------------------------------------
// aafo_sqrt
// Pipelined restoring integer square root, one root bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module aafo_sqrt #(
    parameter int RAD_W = aafo_pkg::SQRT_RAD_W,
    parameter int TAG_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [RAD_W-1:0]     in_rad,
    input  logic [TAG_W-1:0]     in_tag,
    output logic                 out_valid,
    output logic [RAD_W/2-1:0]   out_root,
    output logic [TAG_W-1:0]     out_tag
);
    import aafo_pkg::*;

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;

    logic              v_reg    [ROOT_W+1];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W+1];
    logic [REM_W-1:0]  rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0] root_reg [ROOT_W+1];
    logic [TAG_W-1:0]  tag_reg  [ROOT_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg[0]  <= in_rad;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            tag_reg[0]  <= in_tag;
        end
    end

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_stage
        logic [REM_W-1:0] rem_in, trial;

        assign rem_in = {rem_reg[i][REM_W-3:0], rad_reg[i][RAD_W-1 -: 2]};
        assign trial  = REM_W'({root_reg[i], 2'b01});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[i+1] <= {rad_reg[i][RAD_W-3:0], 2'b00};
                tag_reg[i+1] <= tag_reg[i];
                if (rem_in >= trial)
                begin
                    rem_reg[i+1]  <= rem_in - trial;
                    root_reg[i+1] <= {root_reg[i][ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1]  <= rem_in;
                    root_reg[i+1] <= {root_reg[i][ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = v_reg[ROOT_W];
    assign out_root  = root_reg[ROOT_W];
    assign out_tag   = tag_reg[ROOT_W];

endmodule

`default_nettype wire

@@ rtl/aafo_cordic.sv @@
// ---------------------------------------------------------------------------
// aafo_cordic
// Pipelined vectoring CORDIC: normalises the input pair, then one
// micro-rotation per stage, giving atan2(y, x) in Q30 for x >= 0.
// ---------------------------------------------------------------------------
`default_nettype none

module aafo_cordic #(
    parameter int STAGES = aafo_pkg::CORDIC_STAGES_DEF,
    parameter int TAG_W  = 1
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic signed [aafo_pkg::CORDIC_IN_W-1:0] in_x,
    input  logic signed [aafo_pkg::CORDIC_IN_W-1:0] in_y,
    input  logic [TAG_W-1:0]                       in_tag,
    output logic                                   out_valid,
    output logic signed [aafo_pkg::Z_W-1:0]        out_z,
    output logic [TAG_W-1:0]                       out_tag
);
    import aafo_pkg::*;

    logic [CORDIC_IN_W-1:0] abs_x, abs_y, mag;
    logic [6:0]             top_bit;
    logic [5:0]             norm_sh;
    logic signed [XY_W-1:0] x_norm, y_norm;

    logic                   v_reg   [STAGES+1];
    logic signed [XY_W-1:0] x_reg   [STAGES+1];
    logic signed [XY_W-1:0] y_reg   [STAGES+1];
    logic signed [Z_W-1:0]  z_reg   [STAGES+1];
    logic [TAG_W-1:0]       tag_reg [STAGES+1];

    // Left shift so that the larger magnitude lands in [2^40, 2^41).
    always_comb
    begin
        abs_x   = in_x[CORDIC_IN_W-1] ? -in_x : in_x;
        abs_y   = in_y[CORDIC_IN_W-1] ? -in_y : in_y;
        mag     = (abs_x > abs_y) ? abs_x : abs_y;
        top_bit = msb_index(64'(mag));
        norm_sh = (mag == '0) ? '0 : 6'(NORM_MSB - int'(top_bit));
        x_norm  = XY_W'(in_x) <<< norm_sh;
        y_norm  = XY_W'(in_y) <<< norm_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= x_norm;
            y_reg[0]   <= y_norm;
            z_reg[0]   <= '0;
            tag_reg[0] <= in_tag;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic signed [XY_W-1:0] xs, ys;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tag_reg[i+1] <= tag_reg[i];
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + atan_entry(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - atan_entry(i);
                end
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign out_z     = z_reg[STAGES];
    assign out_tag   = tag_reg[STAGES];

endmodule

`default_nettype wire

@@ rtl/aim_angle_from_offset_core.sv @@
// ---------------------------------------------------------------------------
// aim_angle_from_offset_core
// Rotation angle toward an integer direction, with a muzzle offset
// correction, as Q4.12 radians from a pair of pipelined CORDIC units.
// ---------------------------------------------------------------------------
//
//  Channel | Signals                         | Transaction carries
//  --------+---------------------------------+-----------------------------------
//  s_      | s_tvalid s_tready s_tdata s_tuser | dir_x, dir_y, aim_radius, mirror
//  m_      | m_tvalid m_tready m_tdata       | angle
//
// One transaction is taken every cycle while the output side keeps up.
// Most of the path from an accepted input to its result lies in the
// 32-stage square root that feeds the correction CORDIC.
// Reset is asynchronous and active low; it empties the queue and the pipeline.
// When the result register is held, the whole arithmetic pipeline stalls and
// the input queue absorbs the next transactions until it is full.
//
`default_nettype none
`include "aim_angle_from_offset_core_macros.svh"

module aim_angle_from_offset_core #(
    parameter int COORD_WIDTH     = aafo_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = aafo_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = aafo_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // s_tdata, from bit 0 up: dir_x, dir_y, aim_radius, zero padding to bytes
    input  logic [((2*COORD_WIDTH+aafo_pkg::RADIUS_W+7)/8)*8-1:0] s_tdata,
    // s_tuser: mirror
    input  logic                                      s_tuser,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // m_tdata, from bit 0 up: angle
    output logic [aafo_pkg::ANGLE_W-1:0]              m_tdata
);
    import aafo_pkg::*;

    localparam int W         = COORD_WIDTH;
    localparam int L2_W      = 2 * W;
    localparam int RSQ_W     = 2 * RADIUS_W;
    localparam int CLS_W     = $bits(aafo_cls_t);
    localparam int ROOT_W    = SQRT_RAD_W / 2;
    localparam int SQ_TAG_W  = YK_W + W + (W + 1) + CLS_W + 1;
    localparam int RND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [ANG_W-1:0] RND_HALF = ANG_W'(64'd1 << (RND_SHIFT - 1));

    // The whole back end moves one step whenever the result register can take
    // a new value.
    logic adv;
    assign adv = !m_tvalid || m_tready;

    // Front: classification and queue.
    logic                  q_valid;
    logic [W-1:0]          q_ux, q_uy;
    logic signed [W:0]     q_cy;
    logic [RADIUS_W-1:0]   q_radius;
    aafo_cls_t             q_cls;

    aafo_front #(
        .COORD_WIDTH (W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .dir_x      ($signed(s_tdata[W-1:0])),
        .dir_y      ($signed(s_tdata[2*W-1:W])),
        .aim_radius (s_tdata[2*W+RADIUS_W-1:2*W]),
        .mirror     (s_tuser),
        .pop        (adv && q_valid),
        .out_valid  (q_valid),
        .out_ux     (q_ux),
        .out_uy     (q_uy),
        .out_cy     (q_cy),
        .out_radius (q_radius),
        .out_cls    (q_cls)
    );

    // Stage 1: squares of the two magnitudes and of the radius.
    logic                s1_valid_reg;
    logic [L2_W-1:0]     s1_xx_reg, s1_yy_reg;
    logic [RSQ_W-1:0]    s1_rr_reg;
    logic [W-1:0]        s1_cx_reg;
    logic signed [W:0]   s1_cy_reg;
    logic [RADIUS_W-1:0] s1_radius_reg;
    aafo_cls_t           s1_cls_reg;

    // Stage 2: squared length minus squared radius, and whether the muzzle
    // correction applies at all.
    logic                  s2_valid_reg;
    logic [SQRT_RAD_W-1:0] s2_diff_reg, s2_diff_next;
    logic                  s2_corr_reg, s2_corr_next;
    logic [W-1:0]          s2_cx_reg;
    logic signed [W:0]     s2_cy_reg;
    logic [RADIUS_W-1:0]   s2_radius_reg;
    aafo_cls_t             s2_cls_reg;
    logic [SQRT_RAD_W-1:0] l2_ext, rr_ext;

    // Stage 3: even left shift of the radicand, with the radius scaled by half
    // of that shift so that the ratio is kept.
    logic                  s3_valid_reg;
    logic [SQRT_RAD_W-1:0] s3_rad_reg, s3_rad_next;
    logic [YK_W-1:0]       s3_yk_reg, s3_yk_next;
    logic                  s3_corr_reg;
    logic [W-1:0]          s3_cx_reg;
    logic signed [W:0]     s3_cy_reg;
    aafo_cls_t             s3_cls_reg;
    logic [6:0]            diff_top;
    logic [5:0]            k_raw, k_even;

    always_comb
    begin
        l2_ext       = SQRT_RAD_W'(s1_xx_reg + s1_yy_reg);
        rr_ext       = SQRT_RAD_W'(s1_rr_reg);
        s2_corr_next = (s1_radius_reg != '0) && (l2_ext != '0) && (rr_ext <= l2_ext);
        s2_diff_next = l2_ext - rr_ext;
    end

    always_comb
    begin
        diff_top = msb_index(s2_diff_reg);
        k_raw    = (int'(diff_top) >= SQRT_TOP_BIT) ? '0
                                                   : 6'(SQRT_TOP_BIT - int'(diff_top));
        k_even   = k_raw + 6'(k_raw[0]);
        if (s2_diff_reg == '0 || k_even > 6'(SQRT_MAX_K))
        begin
            k_even = 6'(SQRT_MAX_K);
        end
        s3_rad_next = s2_diff_reg << k_even;
        s3_yk_next  = YK_W'(s2_radius_reg) << k_even[5:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= q_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_xx_reg     <= q_ux * q_ux;
            s1_yy_reg     <= q_uy * q_uy;
            s1_rr_reg     <= q_radius * q_radius;
            s1_cx_reg     <= q_ux;
            s1_cy_reg     <= q_cy;
            s1_radius_reg <= q_radius;
            s1_cls_reg    <= q_cls;

            s2_diff_reg   <= s2_diff_next;
            s2_corr_reg   <= s2_corr_next;
            s2_cx_reg     <= s1_cx_reg;
            s2_cy_reg     <= s1_cy_reg;
            s2_radius_reg <= s1_radius_reg;
            s2_cls_reg    <= s1_cls_reg;

            s3_rad_reg    <= s3_rad_next;
            s3_yk_reg     <= s3_yk_next;
            s3_corr_reg   <= s2_corr_reg;
            s3_cx_reg     <= s2_cx_reg;
            s3_cy_reg     <= s2_cy_reg;
            s3_cls_reg    <= s2_cls_reg;
        end
    end

    // Square root of the normalised radicand; the direction rides alongside.
    logic                sq_valid;
    logic [ROOT_W-1:0]   sq_root;
    logic [SQ_TAG_W-1:0] sq_tag;
    logic [YK_W-1:0]     sq_yk;
    logic [W-1:0]        sq_cx;
    logic signed [W:0]   sq_cy;
    aafo_cls_t           sq_cls;
    logic                sq_corr;

    aafo_sqrt #(
        .RAD_W (SQRT_RAD_W),
        .TAG_W (SQ_TAG_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s3_valid_reg),
        .in_rad    (s3_rad_reg),
        .in_tag    ({s3_yk_reg, s3_cx_reg, s3_cy_reg, s3_cls_reg, s3_corr_reg}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_tag   (sq_tag)
    );

    assign {sq_yk, sq_cx, sq_cy, sq_cls, sq_corr} = sq_tag;

    // Two CORDIC units side by side: the base angle of the direction and the
    // muzzle correction asin(r/L) = atan2(r, sqrt(L*L - r*r)).
    logic                  main_valid, corr_valid;
    logic signed [Z_W-1:0] main_z, corr_z;
    logic [CLS_W-1:0]      main_tag;
    logic                  corr_tag;
    aafo_cls_t             main_cls;

    aafo_cordic #(
        .STAGES (CORDIC_STAGES),
        .TAG_W  (CLS_W)
    ) u_cordic_main (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sq_valid),
        .in_x      ($signed(CORDIC_IN_W'(sq_cx))),
        .in_y      (CORDIC_IN_W'(sq_cy)),
        .in_tag    (sq_cls),
        .out_valid (main_valid),
        .out_z     (main_z),
        .out_tag   (main_tag)
    );

    aafo_cordic #(
        .STAGES (CORDIC_STAGES),
        .TAG_W  (1)
    ) u_cordic_corr (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sq_valid),
        .in_x      ($signed(CORDIC_IN_W'(sq_root))),
        .in_y      ($signed(CORDIC_IN_W'(sq_yk))),
        .in_tag    (sq_corr),
        .out_valid (corr_valid),
        .out_z     (corr_z),
        .out_tag   (corr_tag)
    );

    assign main_cls = aafo_cls_t'(main_tag);

    // Sum stage: quadrant fix-up plus or minus the correction, in Q30.
    logic                    sum_valid_reg;
    logic signed [ANG_W-1:0] sum_ang_reg, sum_ang_next;
    logic signed [ANG_W-1:0] base_ang, corr_ang;

    always_comb
    begin
        if (main_cls.dx_zero)
        begin
            base_ang = main_cls.dy_pos ? -HALF_PI_Q30 : HALF_PI_Q30;
        end
        else
        begin
            base_ang = ANG_W'(main_z);
            if (main_cls.dx_neg && !main_cls.mirror)
            begin
                base_ang = base_ang + PI_Q30;
            end
        end
        corr_ang = corr_tag ? ANG_W'(corr_z) : '0;
        if (main_cls.mirror && main_cls.dx_neg)
        begin
            sum_ang_next = base_ang + corr_ang;
        end
        else
        begin
            sum_ang_next = base_ang - corr_ang;
        end
    end

    // Output register: round half up to ANGLE_FRAC_BITS, keep the low bits.
    logic                    m_tvalid_reg;
    logic [ANGLE_W-1:0]      m_tdata_reg;
    logic signed [ANG_W-1:0] rounded;

    assign rounded = (sum_ang_reg + RND_HALF) >>> RND_SHIFT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            sum_valid_reg <= main_valid;
            m_tvalid_reg  <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_ang_reg <= sum_ang_next;
            m_tdata_reg <= rounded[ANGLE_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `AAFO_ASSERT_IMP(a_cordic_aligned, clk, rst_n, 1'b1, main_valid == corr_valid, "CORDIC units out of step")
    `AAFO_ASSERT_IMP(a_stall_cause, clk, rst_n, !adv, m_tvalid, "pipeline stalled without a pending result")
    `AAFO_ASSERT_NXT(a_stall_holds_sum, clk, rst_n, !adv, $stable(sum_valid_reg), "sum stage moved during a stall")

endmodule

`default_nettype wire

@@ dv/aim_angle_from_offset_core_tb.sv @@
// ---------------------------------------------------------------------------
// aim_angle_from_offset_core_tb
// Self-checking bench for the aim angle core. Directions, radii and mirror
// flags are streamed in under several idling mixes. Each result is compared
// with an angle worked out here by a bit-exact CORDIC and square root model.
// ---------------------------------------------------------------------------
`default_nettype none

module aim_angle_from_offset_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLE_FRAC = aafo_pkg::ANGLE_FRAC_BITS_DEF;
    localparam int STAGES     = aafo_pkg::CORDIC_STAGES_DEF;
    localparam int LATENCY    = STAGES + 39;
    localparam int TDATA_W    = ((2 * 16 + aafo_pkg::RADIUS_W + 7) / 8) * 8;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint PI_Q30      = 64'sd3373259426;

    // atan(2^-i) in Q30, truncated.
    localparam longint ATAN_Q30 [24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata;   // dir_x, dir_y, aim_radius, zero padding
    logic                s_tuser;   // mirror
    logic                m_tvalid;
    logic                m_tready;
    logic [15:0]         m_tdata;   // angle

    logic [15:0] angle_queue[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_left;

    aim_angle_from_offset_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Vectoring CORDIC returning atan2(y, x) in Q30 for x >= 0. The larger
    // magnitude is first brought into [2^40, 2^41) by floor shifts or doubling.
    function automatic longint atan2_q30(input longint x_in, input longint y_in);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint mag;
        x   = x_in;
        y   = y_in;
        z   = 0;
        mag = (x < 0 ? -x : x) > (y < 0 ? -y : y) ? (x < 0 ? -x : x) : (y < 0 ? -y : y);
        while (mag >= (64'sd1 << 41))
        begin
            x   = x >>> 1;
            y   = y >>> 1;
            mag = mag >>> 1;
        end
        while (mag != 0 && mag < (64'sd1 << 40))
        begin
            x   = x * 2;
            y   = y * 2;
            mag = mag * 2;
        end
        for (int i = 0; i < STAGES && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_Q30[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_Q30[i];
            end
        end
        return z;
    endfunction

    // Exact integer square root, bit by bit.
    function automatic longint unsigned isqrt(input longint unsigned s_in);
        longint unsigned s;
        longint unsigned res;
        longint unsigned b;
        s   = s_in;
        res = 0;
        b   = 64'd1 << 62;
        while (b > s)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (s >= res + b)
            begin
                s   = s - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Expected aim angle, Q4.12 radians, for one direction.
    function automatic logic [15:0] aim_angle(input logic signed [15:0] dir_x,
                                              input logic signed [15:0] dir_y,
                                              input logic [14:0] radius,
                                              input logic mirror);
        longint          dx;
        longint          dy;
        longint          ang;
        longint          corr;
        longint unsigned l2;
        longint unsigned r2;
        longint unsigned rem;
        int              k;
        dx = dir_x;
        dy = dir_y;
        l2 = dx * dx + dy * dy;
        r2 = longint'(radius) * longint'(radius);
        if (dx == 0)
        begin
            ang = (dy > 0) ? -HALF_PI_Q30 : HALF_PI_Q30;
        end
        else if (dx > 0)
        begin
            ang = atan2_q30(dx, -dy);
        end
        else
        begin
            ang = atan2_q30(-dx, dy);
            if (!mirror)
            begin
                ang = ang + PI_Q30;
            end
        end
        // Muzzle correction asin(r/L) as atan2(r, sqrt(L^2 - r^2)).
        if (radius != 0 && l2 != 0 && r2 <= l2)
        begin
            rem = l2 - r2;
            k   = 0;
            while (k < 32 && rem < (64'd1 << 61))
            begin
                rem = rem << 2;
                k   = k + 2;
            end
            corr = atan2_q30(longint'(isqrt(rem)), longint'(radius) << (k / 2));
            ang  = (mirror && dx < 0) ? ang + corr : ang - corr;
        end
        ang = (ang + (64'sd1 << (29 - ANGLE_FRAC))) >>> (30 - ANGLE_FRAC);
        return ang[15:0];
    endfunction

    // Offers one direction and waits for it to be taken; the expected angle
    // is queued at the accepting edge.
    task automatic send_aim(input logic [15:0] dir_x, input logic [15:0] dir_y,
                            input logic [14:0] radius, input logic mirror);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, radius, dir_y, dir_x};
        s_tuser  <= mirror;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        angle_queue.push_back(aim_angle(dir_x, dir_y, radius, mirror));
    endtask

    // Lowers valid and waits until every expected angle has come back, then
    // lets the pipeline settle.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (angle_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // One random direction. Most have a radius no greater than the length so
    // that the correction is exercised, including the radius-equals-length edge.
    task automatic send_random;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [14:0] r;
        int          mode;
        int          len;
        mode = $urandom_range(9);
        if (mode < 3)
        begin
            dx = 16'($signed($urandom_range(128)) - 64);
            dy = 16'($signed($urandom_range(128)) - 64);
        end
        else
        begin
            dx = 16'($urandom);
            dy = 16'($urandom);
        end
        len = $rtoi($sqrt(real'($signed(dx)) ** 2 + real'($signed(dy)) ** 2));
        if (len > 32767)
        begin
            len = 32767;
        end
        case ($urandom_range(4))
            0:       r = 15'($urandom);
            1:       r = 15'd0;
            2:       r = 15'(len);
            default: r = 15'($urandom_range(len));
        endcase
        send_aim(dx, dy, r, 1'($urandom));
    endtask

    task automatic test_directed;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // Zero direction, with and without radius.
        send_aim(16'sd0, 16'sd0, 15'd0, 1'b0);
        send_aim(16'sd0, 16'sd0, 15'd100, 1'b1);
        // Axes.
        send_aim(16'sd0, -16'sd5, 15'd0, 1'b0);
        send_aim(16'sd0, 16'sd5, 15'd0, 1'b0);
        send_aim(16'sd7, 16'sd0, 15'd0, 1'b0);
        send_aim(-16'sd7, 16'sd0, 15'd0, 1'b0);
        send_aim(-16'sd7, 16'sd0, 15'd0, 1'b1);
        // Field extremes.
        send_aim(16'h8000, 16'h8000, 15'h7FFF, 1'b0);
        send_aim(16'h8000, 16'h7FFF, 15'h7FFF, 1'b1);
        send_aim(16'h7FFF, 16'h8000, 15'h7FFF, 1'b1);
        send_aim(16'h7FFF, 16'h7FFF, 15'h7FFF, 1'b0);
        send_aim(16'hFFFF, 16'hFFFF, 15'd1, 1'b0);
        send_aim(16'sd1, 16'sd1, 15'd1, 1'b1);
        // Radius equal to the length.
        send_aim(16'sd3, 16'sd4, 15'd5, 1'b0);
        send_aim(-16'sd3, -16'sd4, 15'd5, 1'b1);
        send_aim(16'sd0, 16'sd9, 15'd9, 1'b0);
        // Radius beyond the length.
        send_aim(16'sd3, 16'sd4, 15'd6, 1'b0);
        send_aim(-16'sd3, 16'sd4, 15'd6, 1'b1);
        // Correction sign flip for mirrored leftward aim.
        send_aim(-16'sd300, -16'sd200, 15'd50, 1'b1);
        send_aim(-16'sd300, -16'sd200, 15'd50, 1'b0);
        send_aim(16'sd300, -16'sd200, 15'd50, 1'b1);
        drain();
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_random();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering more transactions than the pipeline and queue can hold, so
    // the queue fills and the input stalls.
    task automatic test_backpressure;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 300;
        repeat (120) send_random();
        drain();
    endtask

    // Receiver: random stalls, plus an occasional long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker: each accepted angle against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (angle_queue.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected angle %h", $time, m_tdata);
            end
            else if (m_tdata !== angle_queue[0])
            begin
                mismatches++;
                $display("%0t: angle mismatch, expected %h, actual %h",
                         $time, angle_queue[0], m_tdata);
                void'(angle_queue.pop_front());
            end
            else
            begin
                void'(angle_queue.pop_front());
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(250, 0, 0);
        test_random(200, 78, 0);
        drain();
        test_random(200, 0, 78);
        test_random(200, 31, 31);
        test_backpressure();
        test_random(80, $urandom_range(60), $urandom_range(60));
        drain();

        if (mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/aafo_pkg.sv
rtl/aafo_queue.sv
rtl/aafo_front.sv
rtl/aafo_sqrt.sv
rtl/aafo_cordic.sv
rtl/aim_angle_from_offset_core.sv
dv/aim_angle_from_offset_core_tb.sv
